>>> src/qrm_pkg.sv
`timescale 1ns / 1ps
// Shared types and widths for the quaternion to rotation matrix core.
// Depends on nothing; every other file imports it.
package qrm_pkg;

  localparam int CW        = 32;         // component width, Q2.29
  localparam int PW        = 2 * CW;     // unsigned product width
  localparam int N2W       = PW + 1;     // squared norm width
  localparam int EW        = PW + 4;     // signed entry sum width
  localparam int MAGW      = EW - 1;     // entry magnitude width
  localparam int RW        = N2W;        // divider remainder width
  localparam int QW        = 32;         // quotient width
  localparam int DIV_STEPS = QW;
  localparam int LANE_LAT  = DIV_STEPS + 2;
  localparam int NCOMP     = 4;
  localparam int NCROSS    = 6;
  localparam int NENT      = 9;

  // cross products: xy, wz, xz, wy, yz, wx (w=0, x=1, y=2, z=3)
  localparam int CR_I [NCROSS] = '{1, 0, 1, 0, 2, 0};
  localparam int CR_J [NCROSS] = '{2, 3, 3, 2, 3, 1};

  typedef struct packed {
    logic signed [CW-1:0] q_w;
    logic signed [CW-1:0] q_x;
    logic signed [CW-1:0] q_y;
    logic signed [CW-1:0] q_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic               zero_input;
  } out_word_t;

  typedef struct packed {
    logic vld;
    logic norm;
    logic zero;
  } ctl_t;

endpackage

>>> src/qrm_front.sv
`timescale 1ns / 1ps
// Front stages: magnitudes, products, entry sums and entry magnitudes.
// Depends on qrm_pkg.
module qrm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic                      in_norm,
  input  qrm_pkg::in_word_t         in_q,
  output qrm_pkg::ctl_t             ctl,
  output logic [qrm_pkg::MAGW-1:0]  mag [qrm_pkg::NENT],
  output logic                      neg [qrm_pkg::NENT],
  output logic [qrm_pkg::N2W-1:0]   n2
);
  import qrm_pkg::*;

  logic [CW-1:0]        raw [NCOMP];
  logic [CW-1:0]        mag_a_r [NCOMP];
  logic                 neg_a_r [NCOMP];
  logic [PW-1:0]        sq_b_r [NCOMP];
  logic [PW-1:0]        cr_b_r [NCROSS];
  logic                 crn_b_r [NCROSS];
  logic signed [EW-1:0] s_sq [NCOMP];
  logic signed [EW-1:0] s_cr [NCROSS];
  logic signed [EW-1:0] e_nxt [NENT];
  logic [N2W-1:0]       n2_nxt;
  logic signed [EW-1:0] e_c_r [NENT];
  logic [N2W-1:0]       n2_c_r;
  logic [MAGW-1:0]      mag_d_r [NENT];
  logic                 neg_d_r [NENT];
  logic [N2W-1:0]       n2_d_r;
  ctl_t                 ctl_a_r, ctl_b_r, ctl_c_r, ctl_d_r;

  always_comb begin
    raw[0] = in_q.q_w;
    raw[1] = in_q.q_x;
    raw[2] = in_q.q_y;
    raw[3] = in_q.q_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
      ctl_d_r <= '0;
    end else begin
      ctl_a_r.vld  <= in_vld;
      ctl_a_r.norm <= in_norm;
      ctl_a_r.zero <= (in_q == '0);
      ctl_b_r      <= ctl_a_r;
      ctl_c_r      <= ctl_b_r;
      ctl_d_r      <= ctl_c_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NCOMP; i++) begin
      neg_a_r[i] <= raw[i][CW-1];
      mag_a_r[i] <= raw[i][CW-1] ? CW'(-raw[i]) : raw[i];
      sq_b_r[i]  <= PW'(mag_a_r[i]) * PW'(mag_a_r[i]);
    end
    for (int k = 0; k < NCROSS; k++) begin
      cr_b_r[k]  <= PW'(mag_a_r[CR_I[k]]) * PW'(mag_a_r[CR_J[k]]);
      crn_b_r[k] <= neg_a_r[CR_I[k]] ^ neg_a_r[CR_J[k]];
    end
  end

  always_comb begin
    for (int i = 0; i < NCOMP; i++) s_sq[i] = $signed({4'b0, sq_b_r[i]});
    for (int k = 0; k < NCROSS; k++) begin
      s_cr[k] = crn_b_r[k] ? -$signed({4'b0, cr_b_r[k]}) : $signed({4'b0, cr_b_r[k]});
    end
    e_nxt[0] = s_sq[0] + s_sq[1] - s_sq[2] - s_sq[3];
    e_nxt[1] = (s_cr[0] - s_cr[1]) <<< 1;
    e_nxt[2] = (s_cr[2] + s_cr[3]) <<< 1;
    e_nxt[3] = (s_cr[0] + s_cr[1]) <<< 1;
    e_nxt[4] = s_sq[0] - s_sq[1] + s_sq[2] - s_sq[3];
    e_nxt[5] = (s_cr[4] - s_cr[5]) <<< 1;
    e_nxt[6] = (s_cr[2] - s_cr[3]) <<< 1;
    e_nxt[7] = (s_cr[4] + s_cr[5]) <<< 1;
    e_nxt[8] = s_sq[0] - s_sq[1] - s_sq[2] + s_sq[3];
    n2_nxt   = {1'b0, sq_b_r[0]} + {1'b0, sq_b_r[1]} + {1'b0, sq_b_r[2]} + {1'b0, sq_b_r[3]};
  end

  always_ff @(posedge clk) begin
    n2_c_r <= n2_nxt;
    n2_d_r <= n2_c_r;
    for (int k = 0; k < NENT; k++) begin
      e_c_r[k]   <= e_nxt[k];
      neg_d_r[k] <= e_c_r[k][EW-1];
      mag_d_r[k] <= e_c_r[k][EW-1] ? MAGW'(-e_c_r[k]) : MAGW'(e_c_r[k]);
    end
  end

  assign ctl = ctl_d_r;
  assign mag = mag_d_r;
  assign neg = neg_d_r;
  assign n2  = n2_d_r;

endmodule

>>> src/qrm_div.sv
`timescale 1ns / 1ps
// One entry lane: saturating raw rounding and a pipelined restoring divider.
// Depends on qrm_pkg.
module qrm_div (
  input  logic                      clk,
  input  logic                      in_norm,
  input  logic                      in_neg,
  input  logic [qrm_pkg::MAGW-1:0]  in_mag,
  input  logic [qrm_pkg::N2W-1:0]   in_n2,
  output logic [31:0]               out_ent
);
  import qrm_pkg::*;

  localparam int VW = MAGW - 27;
  localparam logic [MAGW:0] RND_HALF = {{(MAGW-27){1'b0}}, 1'b1, 27'b0};

  logic [MAGW:0]   rd;
  logic [VW-1:0]   v;
  logic [VW-1:0]   lim;
  logic [31:0]     v32;
  logic [RW-1:0]   r_r    [DIV_STEPS+1];
  logic [QW-1:0]   q_r    [DIV_STEPS+1];
  logic [N2W-1:0]  n2_r   [DIV_STEPS+1];
  logic            neg_r  [DIV_STEPS+1];
  logic            norm_r [DIV_STEPS+1];
  logic [31:0]     raw_r  [DIV_STEPS+1];
  logic            b0_r;
  logic [QW:0]     qrnd;
  logic [31:0]     qres;
  logic [31:0]     ent_r;

  always_comb begin
    rd   = {1'b0, in_mag} + RND_HALF;
    v    = rd[MAGW:28];
    lim  = in_neg ? VW'(64'h8000_0000) : VW'(64'h7FFF_FFFF);
    v32  = (v > lim) ? lim[31:0] : v[31:0];
  end

  always_ff @(posedge clk) begin
    r_r[0]    <= in_mag[RW:1];
    b0_r      <= in_mag[0];
    q_r[0]    <= '0;
    n2_r[0]   <= in_n2;
    neg_r[0]  <= in_neg;
    norm_r[0] <= in_norm;
    raw_r[0]  <= in_neg ? -v32 : v32;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [RW:0]   rs;
    logic [RW+1:0] diff;
    logic          ge;

    always_comb begin
      rs   = {r_r[k], (k == 0) ? b0_r : 1'b0};
      diff = {1'b0, rs} - {2'b0, n2_r[k]};
      ge   = !diff[RW+1];
    end

    always_ff @(posedge clk) begin
      r_r[k+1]    <= ge ? diff[RW-1:0] : rs[RW-1:0];
      q_r[k+1]    <= {q_r[k][QW-2:0], ge};
      n2_r[k+1]   <= n2_r[k];
      neg_r[k+1]  <= neg_r[k];
      norm_r[k+1] <= norm_r[k];
      raw_r[k+1]  <= raw_r[k];
    end
  end

  always_comb begin
    qrnd = {1'b0, q_r[DIV_STEPS]} + (QW+1)'(1);
    qres = qrnd[QW:1];
  end

  always_ff @(posedge clk) begin
    if (norm_r[DIV_STEPS]) begin
      ent_r <= neg_r[DIV_STEPS] ? -qres : qres;
    end else begin
      ent_r <= raw_r[DIV_STEPS];
    end
  end

  assign out_ent = ent_r;

endmodule

>>> src/quaternion_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// Quaternion to rotation matrix core: top level with config register and output word.
// Depends on qrm_pkg, qrm_front and qrm_div.
// The result path runs through the front stages, the 32-step divider in each lane and the output register.
// Throughput: one word per cycle; busy is high during reset and in the cycle after it, low otherwise.
// Reset: synchronous active-low rst_n clears valid bits, sets norm_r to 1 and sets busy.
// The receiver cannot stall; every result shows for exactly one cycle.
module quaternion_to_rotation_matrix_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  qrm_pkg::in_word_t   in_word,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  output logic                out_valid,
  output qrm_pkg::out_word_t  out_word
);
  import qrm_pkg::*;

  localparam int LATENCY = 4 + LANE_LAT + 1;

  logic            norm_r;
  logic            busy_r;
  logic            accept;
  ctl_t            fctl;
  logic [MAGW-1:0] fmag [NENT];
  logic            fneg [NENT];
  logic [N2W-1:0]  fn2;
  logic [31:0]     ent [NENT];
  ctl_t            ctl_dl_r [LANE_LAT];
  logic            zero;
  logic            out_valid_r;
  out_word_t       out_word_r;
  out_word_t       out_word_nxt;

  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r <= 1'b1;
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) norm_r <= cfg_wdata;
    end
  end

  qrm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_norm (norm_r),
    .in_q    (in_word),
    .ctl     (fctl),
    .mag     (fmag),
    .neg     (fneg),
    .n2      (fn2)
  );

  for (genvar k = 0; k < NENT; k++) begin : g_lane
    qrm_div u_div (
      .clk     (clk),
      .in_norm (fctl.norm),
      .in_neg  (fneg[k]),
      .in_mag  (fmag[k]),
      .in_n2   (fn2),
      .out_ent (ent[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) ctl_dl_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_dl_r[0] <= fctl;
      for (int i = 1; i < LANE_LAT; i++) ctl_dl_r[i] <= ctl_dl_r[i-1];
      out_valid_r <= ctl_dl_r[LANE_LAT-1].vld;
    end
  end

  always_comb begin
    zero = ctl_dl_r[LANE_LAT-1].zero && ctl_dl_r[LANE_LAT-1].norm;
    out_word_nxt.m00        = zero ? '0 : ent[0];
    out_word_nxt.m01        = zero ? '0 : ent[1];
    out_word_nxt.m02        = zero ? '0 : ent[2];
    out_word_nxt.m10        = zero ? '0 : ent[3];
    out_word_nxt.m11        = zero ? '0 : ent[4];
    out_word_nxt.m12        = zero ? '0 : ent[5];
    out_word_nxt.m20        = zero ? '0 : ent[6];
    out_word_nxt.m21        = zero ? '0 : ent[7];
    out_word_nxt.m22        = zero ? '0 : ent[8];
    out_word_nxt.zero_input = zero;
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, LATENCY) |-> out_valid == $past(start && !busy, LATENCY))
    else $error("result word out of step with accepted word");

  a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.zero_input |->
      out_word.m00 == 0 && out_word.m11 == 0 && out_word.m22 == 0 && out_word.m01 == 0)
    else $error("zero input word carries nonzero entries");

  a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy held after reset");
`endif

endmodule
